// ----- sv/nfba_pkg.sv -----
// Shared widths and sequencer codes for the next-fit partition allocator.
package nfba_pkg;

  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
  localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
  localparam int TOT_BITS   = 20;

  typedef logic [1:0] state_t;

  localparam state_t ST_IDLE = 2'd0;
  localparam state_t ST_SCAN = 2'd1;
  localparam state_t ST_SUM  = 2'd2;
  localparam state_t ST_DONE = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

endpackage

// ----- sv/next_fit_block_allocator_core.sv -----
// Next-fit partition allocator: partition table, scan sequencer and totals pass.
//
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  cfg     | cfg_valid, cfg_ready, cfg_data (block_count)   | in
//  in      | in_valid, in_ready, action, block_index,       | in
//          | size_value                                     |
//  out     | out_valid, out_ready, granted, grant_index,    | out
//          | leftover, internal_total, external_total       |
//
// Load: accept, then a summing pass over block_count partitions, then the result.
// Allocate: a scan of up to block_count partitions, one at a time through the
// single compare/subtract unit, then the summing pass, then the result.
// in_ready is low while an item is in progress.
// Reset (rst, synchronous) clears the table, sets block_count to 16 and the
// next-fit pointer to 15. A result held by out_ready low stalls only the
// final cycle of the following request.
module next_fit_block_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [4:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [nfba_pkg::IDX_BITS-1:0] block_index,
  input  logic [nfba_pkg::SIZE_BITS-1:0] size_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          granted,
  output logic [nfba_pkg::IDX_BITS-1:0] grant_index,
  output logic [nfba_pkg::SIZE_BITS-1:0] leftover,
  output logic [nfba_pkg::TOT_BITS-1:0] internal_total,
  output logic [nfba_pkg::TOT_BITS-1:0] external_total
);
  import nfba_pkg::*;

  logic [SIZE_BITS-1:0] part_size     [MAX_BLOCKS];
  logic                 part_used     [MAX_BLOCKS];
  logic [SIZE_BITS-1:0] part_leftover [MAX_BLOCKS];
  logic [IDX_BITS-1:0]  last_grant;
  logic                 refusal_seen;
  logic [CNT_BITS-1:0]  block_count;

  state_t               state;
  logic [IDX_BITS-1:0]  ptr;
  logic [CNT_BITS-1:0]  step;
  logic [SIZE_BITS-1:0] req_size;
  logic                 res_granted;
  logic [IDX_BITS-1:0]  res_index;
  logic [SIZE_BITS-1:0] res_left;
  logic [TOT_BITS-1:0]  acc_int;
  logic [TOT_BITS-1:0]  acc_ext;

  logic [CNT_BITS-1:0]  ptr_inc;
  logic [CNT_BITS-1:0]  step_inc;
  logic [CNT_BITS-1:0]  start_inc;
  logic [IDX_BITS-1:0]  start_pos;
  logic [IDX_BITS-1:0]  ptr_wrap;
  logic [CNT_BITS-1:0]  cfg_clamped;
  logic                 fits;
  logic [SIZE_BITS-1:0] cur_size;
  logic                 cur_used;
  logic                 out_free;

  // count only changes with nothing in flight and no request offered
  assign cfg_ready = (state == ST_IDLE) && !out_valid && !in_valid;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign cur_size  = part_size[ptr];
  assign cur_used  = part_used[ptr];
  assign fits      = !cur_used && (cur_size >= req_size);

  assign ptr_inc   = {1'b0, ptr} + CNT_BITS'(1);
  assign step_inc  = step + CNT_BITS'(1);
  assign ptr_wrap  = (ptr_inc >= block_count) ? '0 : ptr_inc[IDX_BITS-1:0];
  assign start_inc = {1'b0, last_grant} + CNT_BITS'(1);
  assign start_pos = (start_inc >= block_count) ? '0 : start_inc[IDX_BITS-1:0];

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CNT_BITS'(1);
    end else if (cfg_data > CNT_BITS'(MAX_BLOCKS)) begin
      cfg_clamped = CNT_BITS'(MAX_BLOCKS);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        part_size[i]     <= '0;
        part_used[i]     <= 1'b0;
        part_leftover[i] <= '0;
      end
      block_count    <= CNT_BITS'(MAX_BLOCKS);
      last_grant     <= IDX_BITS'(MAX_BLOCKS - 1);
      refusal_seen   <= 1'b0;
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      ptr            <= '0;
      step           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_count <= cfg_clamped;
      end
      // ST_DONE handles out_valid itself
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_size <= size_value;
            if (action == ACT_LOAD) begin
              part_size[block_index]     <= size_value;
              part_used[block_index]     <= 1'b0;
              part_leftover[block_index] <= '0;
              res_granted <= 1'b0;
              res_index   <= '0;
              res_left    <= '0;
              ptr         <= '0;
              acc_int     <= '0;
              acc_ext     <= '0;
              state       <= ST_SUM;
            end else begin
              ptr   <= start_pos;
              step  <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (fits) begin
            part_used[ptr]     <= 1'b1;
            part_leftover[ptr] <= cur_size - req_size;
            last_grant         <= ptr;
            res_granted        <= 1'b1;
            res_index          <= ptr;
            res_left           <= cur_size - req_size;
            ptr                <= '0;
            acc_int            <= '0;
            acc_ext            <= '0;
            state              <= ST_SUM;
          end else if (step_inc == block_count) begin
            // every partition within block_count has been tried
            refusal_seen <= 1'b1;
            res_granted  <= 1'b0;
            res_index    <= '0;
            res_left     <= '0;
            ptr          <= '0;
            acc_int      <= '0;
            acc_ext      <= '0;
            state        <= ST_SUM;
          end else begin
            ptr  <= ptr_wrap;
            step <= step_inc;
          end
        end
        ST_SUM: begin
          if (cur_used) begin
            acc_int <= acc_int + TOT_BITS'(part_leftover[ptr]);
          end else if (refusal_seen) begin
            acc_ext <= acc_ext + TOT_BITS'(cur_size);
          end
          if (ptr_inc == block_count) begin
            state <= ST_DONE;
          end else begin
            ptr <= ptr_inc[IDX_BITS-1:0];
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid      <= 1'b1;
            granted        <= res_granted;
            grant_index    <= res_index;
            leftover       <= res_left;
            internal_total <= acc_int;
            external_total <= acc_ext;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ({1'b0, ptr} < block_count))
    else $error("scan pointer beyond partition count");

  a_refusal_sticky: assert property (@(posedge clk) disable iff (rst)
    refusal_seen |=> refusal_seen)
    else $error("refusal flag cleared outside reset");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !granted) |-> (grant_index == '0 && leftover == '0))
    else $error("refused or load result carries index or leftover");

  a_grant_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> ({1'b0, grant_index} < block_count))
    else $error("granted partition outside count");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (step < block_count))
    else $error("scan ran past partition count");

endmodule
